FILE: hdl/rdsf_pkg.sv
package rdsf_pkg;

   localparam int SLOT_MAX    = 4;
   localparam int PEERS_DEF   = 4;
   localparam int SLOT_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int SEQ_W       = 32;
   localparam int ID_W        = 32;
   localparam int KIND_W      = 8;

   localparam logic [ID_W-1:0]   UNUSED_ID = 32'hffff_ffff;
   localparam logic [KIND_W-1:0] KIND_ACK  = 8'd0;

   typedef enum logic [1:0] {
      VERDICT_DELIVER   = 2'd0,
      VERDICT_DISCARD   = 2'd1,
      VERDICT_UNKNOWN   = 2'd2,
      VERDICT_NOT_READY = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_any;
      logic [SEQ_W-1:0] seq_reliable;
      logic [SEQ_W-1:0] acked_reliable;
   } entry_type;

   typedef struct packed {
      logic              found;
      logic              unused;
      logic [SLOT_W-1:0] slot;
   } match_type;

   typedef struct packed {
      logic              is_ack;
      logic              is_reliable;
      logic [SEQ_W-1:0]  seq_any;
      logic [SEQ_W-1:0]  seq_reliable;
   } hdr_type;

   typedef struct packed {
      verdict_type       verdict;
      logic              ack_needed;
      logic [SEQ_W-1:0]  ack_number;
      logic [SLOT_W-1:0] peer_slot;
   } result_type;

endpackage

FILE: hdl/rdsf_peer_table.sv
module rdsf_peer_table #(
   parameter int PEERS = rdsf_pkg::PEERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [rdsf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rdsf_pkg::ID_W-1:0]         csr_write_data,
   input  logic [rdsf_pkg::ID_W-1:0]         sender_id,
   output rdsf_pkg::match_type               match
);
   import rdsf_pkg::*;

   logic [ID_W-1:0] peer_id_ff [SLOT_MAX];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_MAX; s++) begin
            peer_id_ff[s] <= UNUSED_ID;
         end
      end else if (csr_write_en && (csr_index < CSR_INDEX_W'(SLOT_MAX))) begin
         peer_id_ff[csr_index[SLOT_W-1:0]] <= csr_write_data;
      end
   end

   // lowest matching slot wins
   always_comb begin
      match.found  = 1'b0;
      match.slot   = '0;
      for (int s = PEERS - 1; s >= 0; s--) begin
         if (peer_id_ff[s] == sender_id) begin
            match.found = 1'b1;
            match.slot  = SLOT_W'(s);
         end
      end
      match.unused = (sender_id == UNUSED_ID);
   end

endmodule

FILE: hdl/rdsf_seq_mem.sv
module rdsf_seq_mem #(
   parameter int PEERS = rdsf_pkg::PEERS_DEF,
   parameter int AW    = (PEERS > 1) ? $clog2(PEERS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  rdsf_pkg::entry_type  wr_data,
   input  logic                 clr_en,
   input  logic [AW-1:0]        clr_addr,
   output rdsf_pkg::entry_type  rd_entry
);
   import rdsf_pkg::*;

   entry_type        mem [PEERS];
   entry_type        rdata_ff;
   entry_type        fwd_data_ff;
   logic             fwd_ff;
   logic             rd_vld_ff;
   logic [PEERS-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff    <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // valid bits stand in for a clear of the entry
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         fwd_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (clr_en) begin
            vld_ff[clr_addr] <= 1'b0;
         end else if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            fwd_ff    <= wr_en && (wr_addr == rd_addr);
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_entry = fwd_data_ff;
      end else if (rd_vld_ff) begin
         rd_entry = rdata_ff;
      end else begin
         rd_entry = '0;
      end
   end

   a_clear_drops_valid: assert property (@(posedge clock) disable iff (reset)
      clr_en |=> !vld_ff[$past(clr_addr)])
      else $error("cleared entry still valid");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !clr_en) |=> vld_ff[$past(wr_addr)])
      else $error("written entry not valid");

   a_fwd_needs_write: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !wr_en) |=> !fwd_ff)
      else $error("forward without a write");

endmodule

FILE: hdl/rdsf_rx_rules.sv
module rdsf_rx_rules (
   input  rdsf_pkg::hdr_type     hdr,
   input  rdsf_pkg::match_type   match,
   input  rdsf_pkg::entry_type   entry,
   output rdsf_pkg::result_type  result,
   output logic                  wr_en,
   output rdsf_pkg::entry_type   wr_data
);
   import rdsf_pkg::*;

   logic [SEQ_W-1:0] next_any;
   logic [SEQ_W-1:0] next_rel;
   logic [SEQ_W-1:0] next_ack;
   logic             ack_adv;
   logic             ack;
   verdict_type      verdict;

   assign next_any = entry.seq_any + SEQ_W'(1);
   assign next_rel = entry.seq_reliable + SEQ_W'(1);
   assign next_ack = entry.acked_reliable + SEQ_W'(1);

   always_comb begin
      ack     = 1'b0;
      ack_adv = 1'b0;
      verdict = VERDICT_DISCARD;
      priority if (!match.found) begin
         verdict = VERDICT_UNKNOWN;
      end else if (match.unused) begin
         verdict = VERDICT_NOT_READY;
      end else if (hdr.is_ack) begin
         ack_adv = (hdr.seq_reliable == next_ack);
      end else if (hdr.is_reliable) begin
         if (hdr.seq_reliable == next_rel) begin
            ack     = 1'b1;
            verdict = VERDICT_DELIVER;
         end else if (hdr.seq_reliable <= entry.seq_reliable) begin
            ack = 1'b1;
         end
      end else begin
         if ((hdr.seq_any >= next_any) &&
             (hdr.seq_reliable == entry.seq_reliable)) begin
            verdict = VERDICT_DELIVER;
         end
      end
   end

   always_comb begin
      wr_data = entry;
      if (ack_adv) begin
         wr_data.acked_reliable = hdr.seq_reliable;
      end
      if (verdict == VERDICT_DELIVER) begin
         wr_data.seq_any      = hdr.seq_any;
         wr_data.seq_reliable = hdr.seq_reliable;
      end
   end

   assign wr_en             = ack_adv || (verdict == VERDICT_DELIVER);
   assign result.verdict    = verdict;
   assign result.ack_needed = ack;
   assign result.ack_number = ack ? hdr.seq_reliable : '0;
   assign result.peer_slot  = match.found ? match.slot : '0;

endmodule

FILE: hdl/reliable_datagram_sequence_filter.sv
// channel    | direction | transfer when          | payload
// req_       | in        | req_valid & !req_stall | sender_id, packet_kind, is_reliable, seq_any,
//            |           |                        | seq_reliable
// rsp_       | out       | rsp_valid & !rsp_stall | verdict, ack_needed, ack_number, peer_slot
// csr_       | in        | csr_write_en           | csr_index, csr_write_data (peer ids)
//
// one header per cycle sustained unless a stalled rsp fills both stages; rsp_valid rises as
// stage one passes its header to the result register; stage one: peer id compare and read of the
// slot's state memory, stage two: receive rules, write back of the entry and the result register
// reset clears the peer ids to unused and the state through per-slot valid bits
// a stalled rsp holds the result stage; req_stall rises only while both stages are full
module reliable_datagram_sequence_filter #(
   parameter int PEERS = rdsf_pkg::PEERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rdsf_pkg::ID_W-1:0]         req_sender_id,
   input  logic [rdsf_pkg::KIND_W-1:0]       req_packet_kind,
   input  logic                              req_is_reliable,
   input  logic [rdsf_pkg::SEQ_W-1:0]        req_seq_any,
   input  logic [rdsf_pkg::SEQ_W-1:0]        req_seq_reliable,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_verdict,
   output logic                              rsp_ack_needed,
   output logic [rdsf_pkg::SEQ_W-1:0]        rsp_ack_number,
   output logic [rdsf_pkg::SLOT_W-1:0]       rsp_peer_slot,
   input  logic                              csr_write_en,
   input  logic [rdsf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rdsf_pkg::ID_W-1:0]         csr_write_data
);
   import rdsf_pkg::*;

   localparam int AW = (PEERS > 1) ? $clog2(PEERS) : 1;

   match_type  match_c;
   match_type  s1_match_ff;
   hdr_type    s1_hdr_ff;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       s1_adv;
   logic       req_xfer;
   entry_type  entry;
   entry_type  wr_data;
   logic       rule_wr;
   logic       mem_wr;
   logic       clr_en;
   result_type result_c;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // peer id registers and the parallel compare
   rdsf_peer_table #(.PEERS(PEERS)) u_peer_table (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .sender_id      (req_sender_id),
      .match          (match_c)
   );

   // the rule stage moves on when the result register is free or being emptied
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_xfer  = req_valid && !req_stall;

   // only a peer that is bound and in range ever touches its entry
   assign mem_wr = s1_adv && rule_wr;
   assign clr_en = csr_write_en && (csr_index < CSR_INDEX_W'(PEERS));

   // per-slot sequence state; same-slot back-to-back items are forwarded inside
   rdsf_seq_mem #(.PEERS(PEERS), .AW(AW)) u_seq_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_xfer),
      .rd_addr  (match_c.slot[AW-1:0]),
      .wr_en    (mem_wr),
      .wr_addr  (s1_match_ff.slot[AW-1:0]),
      .wr_data  (wr_data),
      .clr_en   (clr_en),
      .clr_addr (csr_index[AW-1:0]),
      .rd_entry (entry)
   );

   rdsf_rx_rules u_rx_rules (
      .hdr     (s1_hdr_ff),
      .match   (s1_match_ff),
      .entry   (entry),
      .result  (result_c),
      .wr_en   (rule_wr),
      .wr_data (wr_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // header and match ride along with the memory read
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_match_ff            <= match_c;
         s1_hdr_ff.is_ack       <= (req_packet_kind == KIND_ACK);
         s1_hdr_ff.is_reliable  <= req_is_reliable;
         s1_hdr_ff.seq_any      <= req_seq_any;
         s1_hdr_ff.seq_reliable <= req_seq_reliable;
      end
      if (s1_adv) begin
         rsp_ff <= result_c;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_verdict    = rsp_ff.verdict;
   assign rsp_ack_needed = rsp_ff.ack_needed;
   assign rsp_ack_number = rsp_ff.ack_number;
   assign rsp_peer_slot  = rsp_ff.peer_slot;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipe");

   a_unknown_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_verdict == VERDICT_UNKNOWN)) |->
         (!rsp_ack_needed && (rsp_peer_slot == '0)))
      else $error("unknown peer result carries slot or ack");

   a_no_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ack_needed) |-> (rsp_ack_number == '0))
      else $error("ack number set without ack request");

   a_no_write_unbound: assert property (@(posedge clock) disable iff (reset)
      (mem_wr) |-> (s1_match_ff.found && !s1_match_ff.unused))
      else $error("state written for an unbound peer");

endmodule

FILE: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdsf_pkg::*;

   localparam int PEERS           = PEERS_DEF;
   localparam int CYCLE_LIMIT     = 200_000;
   localparam int HOLD_OFF_CYCLES = 50;
   localparam int PHASE_HEADERS   = 270;
   localparam int SETTLE_CYCLES   = 4;
   localparam int REPORT_LIMIT    = 10;

   // one datagram header as offered on the req channel
   typedef struct packed {
      logic [ID_W-1:0]   sender_id;
      logic [KIND_W-1:0] packet_kind;
      logic              is_reliable;
      logic [SEQ_W-1:0]  seq_any;
      logic [SEQ_W-1:0]  seq_reliable;
   } packet_header_type;

   typedef enum logic [0:0] {
      STEP_HEADER = 1'b0,
      STEP_WRITE  = 1'b1
   } step_type;

   // one row of the directed table: a header transfer or a peer id write
   typedef struct packed {
      step_type                step;
      logic [CSR_INDEX_W-1:0]  reg_index;
      logic [ID_W-1:0]         reg_value;
      packet_header_type       header;
      logic                    has_typed;
      result_type              typed;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                   req_valid;
   logic                   req_stall;
   logic [ID_W-1:0]        req_sender_id;
   logic [KIND_W-1:0]      req_packet_kind;
   logic                   req_is_reliable;
   logic [SEQ_W-1:0]       req_seq_any;
   logic [SEQ_W-1:0]       req_seq_reliable;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_verdict;
   logic                   rsp_ack_needed;
   logic [SEQ_W-1:0]       rsp_ack_number;
   logic [SLOT_W-1:0]      rsp_peer_slot;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ID_W-1:0]        csr_write_data;

   // hand-typed expectation that travels with the current req payload
   logic       typed_pending;
   result_type typed_expect;

   // predictor copy of the peer table and per-slot sequence state
   logic [ID_W-1:0]  peer_table        [SLOT_MAX];
   logic [SEQ_W-1:0] accepted_any      [SLOT_MAX];
   logic [SEQ_W-1:0] accepted_reliable [SLOT_MAX];
   logic [SEQ_W-1:0] acked_reliable    [SLOT_MAX];

   result_type       verdict_queue [$];
   directed_row_type directed_table [$];
   int               failure_count = 0;
   int               cycle_count   = 0;
   logic             req_taken     = 1'b0;

   // idle odds per cycle, in percent, and long receiver hold-off requests
   int unsigned req_idle_pct  = 29;
   int unsigned rsp_idle_pct  = 66;
   int          hold_off_asked = 0;
   int          hold_off_done  = 0;
   int          hold_off_left  = 0;

   reliable_datagram_sequence_filter #(
      .PEERS (PEERS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sender_id    (req_sender_id),
      .req_packet_kind  (req_packet_kind),
      .req_is_reliable  (req_is_reliable),
      .req_seq_any      (req_seq_any),
      .req_seq_reliable (req_seq_reliable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict      (rsp_verdict),
      .rsp_ack_needed   (rsp_ack_needed),
      .rsp_ack_number   (rsp_ack_number),
      .rsp_peer_slot    (rsp_peer_slot),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receive rules for one header; updates the predictor state of the matched slot
   function automatic result_type filter_header(input packet_header_type h);
      result_type  r;
      int          slot;
      logic [SEQ_W-1:0] next_any;
      logic [SEQ_W-1:0] next_reliable;
      logic [SEQ_W-1:0] next_acked;
      r    = '0;
      slot = -1;
      // lowest matching slot wins, slots beyond PEERS never match
      for (int s = PEERS - 1; s >= 0; s--) begin
         if (peer_table[s] == h.sender_id) slot = s;
      end
      if (slot < 0) begin
         r.verdict = VERDICT_UNKNOWN;
         return r;
      end
      r.peer_slot = slot[SLOT_W-1:0];
      // all-ones sender hit an unconnected slot
      if (peer_table[slot] == UNUSED_ID) begin
         r.verdict = VERDICT_NOT_READY;
         return r;
      end
      next_any      = accepted_any[slot] + 32'd1;
      next_reliable = accepted_reliable[slot] + 32'd1;
      next_acked    = acked_reliable[slot] + 32'd1;
      r.verdict     = VERDICT_DISCARD;
      if (h.packet_kind == KIND_ACK) begin
         // acks only ever move forward by exactly one
         if (h.seq_reliable == next_acked) acked_reliable[slot] = h.seq_reliable;
      end else if (h.is_reliable) begin
         if (h.seq_reliable == next_reliable) begin
            r.verdict    = VERDICT_DELIVER;
            r.ack_needed = 1'b1;
         end else if (h.seq_reliable <= accepted_reliable[slot]) begin
            // duplicate of something already taken: drop but ack again
            r.ack_needed = 1'b1;
         end
      end else if (h.seq_any >= next_any && h.seq_reliable == accepted_reliable[slot]) begin
         r.verdict = VERDICT_DELIVER;
      end
      if (r.verdict == VERDICT_DELIVER) begin
         accepted_any[slot]      = h.seq_any;
         accepted_reliable[slot] = h.seq_reliable;
      end
      if (r.ack_needed) r.ack_number = h.seq_reliable;
      return r;
   endfunction

   function automatic void note_failure(input string what);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   function automatic void add_row(input directed_row_type row);
      directed_table.insert(directed_table.size(), row);
   endfunction

   // mostly well-formed traffic for a known peer, some unknown senders and noise
   function automatic packet_header_type random_header();
      packet_header_type h;
      int unsigned      slot;
      int unsigned      pick;
      int unsigned      shape;
      logic [SEQ_W-1:0] last_any;
      logic [SEQ_W-1:0] last_rel;
      slot     = $urandom_range(SLOT_MAX - 1);
      pick     = $urandom_range(99);
      shape    = $urandom_range(99);
      last_any = accepted_any[slot];
      last_rel = accepted_reliable[slot];
      h.sender_id   = peer_table[slot];
      h.packet_kind = 8'($urandom_range(1, 255));
      h.is_reliable = 1'b0;
      if (pick < 10) begin
         // pure noise across every field
         h.sender_id    = $urandom();
         h.packet_kind  = 8'($urandom_range(255));
         h.is_reliable  = 1'($urandom_range(1));
         h.seq_any      = $urandom();
         h.seq_reliable = $urandom();
         return h;
      end
      if (pick < 16) h.sender_id = $urandom();
      else if (pick < 19) h.sender_id = UNUSED_ID;
      if (shape < 15) begin
         // ack, reliable flag is don't care
         h.packet_kind  = KIND_ACK;
         h.is_reliable  = 1'($urandom_range(1));
         h.seq_any      = last_any + $urandom_range(1, 3);
         h.seq_reliable = ($urandom_range(99) < 60) ? acked_reliable[slot] + 32'd1
                                                    : acked_reliable[slot] + $urandom_range(4);
      end else if (shape < 55) begin
         // reliable data: next, old or from the future
         h.is_reliable = 1'b1;
         h.seq_any     = last_any + $urandom_range(1, 3);
         pick          = $urandom_range(99);
         if (pick < 60) h.seq_reliable = last_rel + 32'd1;
         else if (pick < 80) h.seq_reliable = last_rel - $urandom_range(3);
         else h.seq_reliable = last_rel + $urandom_range(2, 1000);
      end else begin
         // unreliable data: in order, stale or far off
         pick = $urandom_range(99);
         if (pick < 65) h.seq_any = last_any + $urandom_range(1, 4);
         else if (pick < 80) h.seq_any = last_any - $urandom_range(2);
         else h.seq_any = $urandom();
         pick = $urandom_range(99);
         if (pick < 85) h.seq_reliable = last_rel;
         else if (pick < 93) h.seq_reliable = last_rel + 32'd1;
         else h.seq_reliable = $urandom();
      end
      return h;
   endfunction

   function automatic directed_row_type header_row(input logic [ID_W-1:0] sender,
                                                   input logic [KIND_W-1:0] kind,
                                                   input logic reliable,
                                                   input logic [SEQ_W-1:0] seq_any,
                                                   input logic [SEQ_W-1:0] seq_reliable);
      directed_row_type row;
      row                     = '0;
      row.step                = STEP_HEADER;
      row.header.sender_id    = sender;
      row.header.packet_kind  = kind;
      row.header.is_reliable  = reliable;
      row.header.seq_any      = seq_any;
      row.header.seq_reliable = seq_reliable;
      return row;
   endfunction

   function automatic directed_row_type typed_row(input logic [ID_W-1:0] sender,
                                                  input logic [KIND_W-1:0] kind,
                                                  input logic reliable,
                                                  input logic [SEQ_W-1:0] seq_any,
                                                  input logic [SEQ_W-1:0] seq_reliable,
                                                  input verdict_type verdict,
                                                  input logic ack_needed,
                                                  input logic [SEQ_W-1:0] ack_number,
                                                  input logic [SLOT_W-1:0] slot);
      directed_row_type row;
      row                  = header_row(sender, kind, reliable, seq_any, seq_reliable);
      row.has_typed        = 1'b1;
      row.typed.verdict    = verdict;
      row.typed.ack_needed = ack_needed;
      row.typed.ack_number = ack_number;
      row.typed.peer_slot  = slot;
      return row;
   endfunction

   function automatic directed_row_type write_row(input logic [CSR_INDEX_W-1:0] index,
                                                  input logic [ID_W-1:0] value);
      directed_row_type row;
      row           = '0;
      row.step      = STEP_WRITE;
      row.reg_index = index;
      row.reg_value = value;
      return row;
   endfunction

   // sample side: predictor follows every csr write and req transfer, checker every rsp transfer
   always @(posedge clock) begin
      result_type        predicted;
      result_type        expected;
      packet_header_type seen;
      cycle_count++;
      req_taken = 1'b0;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else if (reset) begin
         for (int s = 0; s < SLOT_MAX; s++) begin
            peer_table[s]        = UNUSED_ID;
            accepted_any[s]      = '0;
            accepted_reliable[s] = '0;
            acked_reliable[s]    = '0;
         end
      end else begin
         // id write rebinds the slot and forgets its history; indexes past the table do nothing
         if (csr_write_en && csr_index < SLOT_MAX) begin
            peer_table[csr_index[SLOT_W-1:0]]        = csr_write_data;
            accepted_any[csr_index[SLOT_W-1:0]]      = '0;
            accepted_reliable[csr_index[SLOT_W-1:0]] = '0;
            acked_reliable[csr_index[SLOT_W-1:0]]    = '0;
         end
         if (req_valid && !req_stall) begin
            seen.sender_id    = req_sender_id;
            seen.packet_kind  = req_packet_kind;
            seen.is_reliable  = req_is_reliable;
            seen.seq_any      = req_seq_any;
            seen.seq_reliable = req_seq_reliable;
            predicted         = filter_header(seen);
            verdict_queue.insert(verdict_queue.size(), typed_pending ? typed_expect : predicted);
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               note_failure($sformatf("unexpected result verdict %0d slot %0d",
                                      rsp_verdict, rsp_peer_slot));
            end else begin
               expected = verdict_queue.pop_front();
               if (rsp_verdict !== expected.verdict || rsp_ack_needed !== expected.ack_needed ||
                   rsp_ack_number !== expected.ack_number ||
                   rsp_peer_slot !== expected.peer_slot) begin
                  note_failure($sformatf(
                     "expected verdict %0d ack %0d num %h slot %0d, got %0d %0d %h %0d",
                     expected.verdict, expected.ack_needed, expected.ack_number,
                     expected.peer_slot, rsp_verdict, rsp_ack_needed, rsp_ack_number,
                     rsp_peer_slot));
               end
            end
         end
      end
   end

   // receiver: random stall, or a long hold-off counted here once asked for
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else if (hold_off_asked != hold_off_done) begin
         hold_off_done = hold_off_asked;
         hold_off_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // offer one header and hold it until the transfer happens
   task automatic send_header(input packet_header_type h, input logic has_typed,
                              input result_type typed);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sender_id    <= h.sender_id;
      req_packet_kind  <= h.packet_kind;
      req_is_reliable  <= h.is_reliable;
      req_seq_any      <= h.seq_any;
      req_seq_reliable <= h.seq_reliable;
      typed_pending    <= has_typed;
      typed_expect     <= typed;
      do @(negedge clock); while (!req_taken);
   endtask

   // sender pauses until every result is back and the pipe has settled
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (verdict_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [ID_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [ID_W-1:0]  phase_ids [3][SLOT_MAX];
      logic [ID_W-1:0]  shared_id;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sender_id    = '0;
      req_packet_kind  = '0;
      req_is_reliable  = 1'b0;
      req_seq_any      = '0;
      req_seq_reliable = '0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      typed_pending    = 1'b0;
      typed_expect     = '0;

      // after reset every slot is unconnected
      add_row(typed_row(UNUSED_ID, 8'd1, 1'b0, 32'd1, 32'd0,
                        VERDICT_NOT_READY, 1'b0, 32'd0, 2'd0));
      add_row(typed_row(32'd0, 8'd1, 1'b1, 32'd1, 32'd1,
                        VERDICT_UNKNOWN, 1'b0, 32'd0, 2'd0));
      // bind slots: zero id, a duplicate pair, an explicitly unused slot, a write past the table
      add_row(write_row(3'd0, 32'h0000_0000));
      add_row(write_row(3'd1, 32'h8000_0001));
      add_row(write_row(3'd2, 32'h8000_0001));
      add_row(write_row(3'd3, UNUSED_ID));
      add_row(write_row(3'd4, 32'h5a5a_5a5a));
      add_row(typed_row(32'h5a5a_5a5a, 8'd1, 1'b0, 32'd1, 32'd0,
                        VERDICT_UNKNOWN, 1'b0, 32'd0, 2'd0));
      add_row(typed_row(UNUSED_ID, 8'd1, 1'b0, 32'd1, 32'd0,
                        VERDICT_NOT_READY, 1'b0, 32'd0, 2'd3));
      // reliable: next, repeat, future
      add_row(typed_row(32'd0, 8'd1, 1'b1, 32'd1, 32'd1,
                        VERDICT_DELIVER, 1'b1, 32'd1, 2'd0));
      add_row(header_row(32'd0, 8'd1, 1'b1, 32'd2, 32'd1));
      add_row(header_row(32'd0, 8'd1, 1'b1, 32'd2, 32'd5));
      // unreliable: stale, in order, reliable still outstanding
      add_row(header_row(32'd0, 8'd2, 1'b0, 32'd1, 32'd1));
      add_row(header_row(32'd0, 8'd2, 1'b0, 32'd2, 32'd1));
      add_row(header_row(32'd0, 8'd2, 1'b0, 32'd3, 32'd0));
      // acks: in step and skipping ahead, reliable flag set on one
      add_row(header_row(32'd0, KIND_ACK, 1'b0, 32'd3, 32'd1));
      add_row(header_row(32'd0, KIND_ACK, 1'b1, 32'd3, 32'd5));
      // duplicate id resolves to the lower slot
      add_row(typed_row(32'h8000_0001, 8'hff, 1'b1, 32'hffff_ffff, 32'd1,
                        VERDICT_DELIVER, 1'b1, 32'd1, 2'd1));
      add_row(header_row(32'h8000_0001, 8'hff, 1'b1, 32'd0, 32'hffff_ffff));
      // overall number wraps: all ones stored, then zero still counts as newer
      add_row(header_row(32'd0, 8'h80, 1'b0, 32'hffff_ffff, 32'd1));
      add_row(header_row(32'd0, 8'h80, 1'b0, 32'd0, 32'd1));
      // unbinding slot 0 makes all-ones land there first
      add_row(write_row(3'd0, UNUSED_ID));
      add_row(typed_row(UNUSED_ID, 8'h7f, 1'b1, 32'd9, 32'd9,
                        VERDICT_NOT_READY, 1'b0, 32'd0, 2'd0));
      // rebinding clears the slot history
      add_row(write_row(3'd0, 32'h0000_0000));
      add_row(typed_row(32'd0, 8'd1, 1'b1, 32'd7, 32'd1,
                        VERDICT_DELIVER, 1'b1, 32'd1, 2'd0));

      // three random settings: random ids, extremes with a duplicate, duplicates at the bottom
      shared_id       = $urandom();
      phase_ids[0][0] = $urandom();
      phase_ids[0][1] = $urandom();
      phase_ids[0][2] = 32'h0000_0000;
      phase_ids[0][3] = $urandom();
      phase_ids[1][0] = UNUSED_ID;
      phase_ids[1][1] = 32'h0000_0001;
      phase_ids[1][2] = 32'hffff_fffe;
      phase_ids[1][3] = 32'h0000_0001;
      phase_ids[2][0] = shared_id;
      phase_ids[2][1] = shared_id;
      phase_ids[2][2] = $urandom();
      phase_ids[2][3] = UNUSED_ID;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_table[i]) begin
         if (directed_table[i].step == STEP_WRITE) begin
            wait_drained();
            write_reg(directed_table[i].reg_index, directed_table[i].reg_value);
         end else begin
            send_header(directed_table[i].header, directed_table[i].has_typed,
                        directed_table[i].typed);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 66 : 0;
         rsp_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 29 : 0;
         wait_drained();
         for (int s = 0; s < SLOT_MAX; s++) write_reg(s[CSR_INDEX_W-1:0], phase_ids[phase][s]);
         // writes past the table must be ignored
         write_reg(3'd7, (phase == 1) ? 32'h0000_0000 : UNUSED_ID);
         write_reg(3'd6, $urandom());
         for (int n = 0; n < PHASE_HEADERS; n++) begin
            if (n == PHASE_HEADERS / 3) hold_off_asked++;
            if (n == 2 * PHASE_HEADERS / 3) wait_drained();
            send_header(random_header(), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (failure_count == 0 && verdict_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
